// File: rtl/upd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Types and constants shared by the upload pacing byte demand block.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int SIZE_BITS  = 24;
    localparam int NEED_BITS  = 24;
    localparam int WIN_BITS   = 16;
    localparam int PROBE_BITS = 20;
    localparam int TIME_BITS  = 32;
    localparam int PROD_BITS  = WIN_BITS + SIZE_BITS;
    localparam int CFG_BITS   = 20;
    localparam int IDX_BITS   = 2;

    localparam logic [IDX_BITS-1:0] CFG_ACCEL_WINDOW  = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_NORMAL_WINDOW = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_IDLE_PROBE    = 2'd2;

    localparam logic [WIN_BITS-1:0]   ACCEL_WINDOW_RESET  = 16'd3000;
    localparam logic [WIN_BITS-1:0]   NORMAL_WINDOW_RESET = 16'd5000;
    localparam logic [PROBE_BITS-1:0] IDLE_PROBE_RESET    = 20'd20000;

    typedef struct packed {
        logic                 link_down;
        logic                 standard_in_progress;
        logic                 standard_queue_empty;
        logic                 control_queue_empty;
        logic                 accelerate_in;
        logic [TIME_BITS-1:0] now_ms;
        logic [TIME_BITS-1:0] last_finished_ms;
        logic [TIME_BITS-1:0] last_call_ms;
        logic [SIZE_BITS-1:0] current_length;
        logic [SIZE_BITS-1:0] current_sent;
        logic [SIZE_BITS-1:0] front_length;
        logic                 front_valid;
    } t_in;

    typedef struct packed {
        logic [NEED_BITS-1:0] needed_bytes;
        logic                 accelerate_out;
    } t_out;

    typedef struct packed {
        logic [WIN_BITS-1:0]   accel_window_ms;
        logic [WIN_BITS-1:0]   normal_window_ms;
        logic [PROBE_BITS-1:0] idle_probe_ms;
    } t_cfg;

    // Data carried from cell to cell along the divider chain.
    typedef struct packed {
        logic                 div_mode;
        logic                 accel;
        logic [WIN_BITS-1:0]  rem;
        logic [SIZE_BITS-1:0] dq;
        logic [WIN_BITS-1:0]  divisor;
        logic [SIZE_BITS-1:0] left;
    } t_cell;

endpackage
`default_nettype wire

// File: rtl/upload_pacing_byte_demand_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upload_pacing_byte_demand_top
// Byte demand of one upload connection within its pacing window.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the skid stage in the
// output buffer is empty, and returns one result for each request, in order.
// The divider is a chain of SIZE_BITS cells that each develop one bit of the
// allowance, behind two decode and multiply stages and the output register.
// Window and probe registers are to be written through the configuration port
// only while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module upload_pacing_byte_demand_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire upd_pkg::t_in                 i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output upd_pkg::t_out                     o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [upd_pkg::IDX_BITS-1:0] i_cfg_index,
    input  wire logic [upd_pkg::CFG_BITS-1:0] i_cfg_data
);

    upd_pkg::t_cfg  r_cfg;
    upd_pkg::t_cell w_cell  [0:upd_pkg::SIZE_BITS];
    logic           w_valid [0:upd_pkg::SIZE_BITS];
    logic           en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_window_ms  <= upd_pkg::ACCEL_WINDOW_RESET;
            r_cfg.normal_window_ms <= upd_pkg::NORMAL_WINDOW_RESET;
            r_cfg.idle_probe_ms    <= upd_pkg::IDLE_PROBE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                upd_pkg::CFG_ACCEL_WINDOW: begin
                    r_cfg.accel_window_ms <= i_cfg_data[upd_pkg::WIN_BITS-1:0];
                end
                upd_pkg::CFG_NORMAL_WINDOW: begin
                    r_cfg.normal_window_ms <= i_cfg_data[upd_pkg::WIN_BITS-1:0];
                end
                upd_pkg::CFG_IDLE_PROBE: begin
                    r_cfg.idle_probe_ms <= i_cfg_data[upd_pkg::PROBE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = en;

    upd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_valid[0]),
        .o_cell  (w_cell[0])
    );

    for (genvar g = 0; g < upd_pkg::SIZE_BITS; g++) begin : g_cell
        upd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    upd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[upd_pkg::SIZE_BITS]),
        .i_cell  (w_cell[upd_pkg::SIZE_BITS]),
        .o_en    (en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: rtl/upd_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_prep
// Decodes a request into window, remainder and timing terms, then forms the
// two schedule products and loads the first divider cell.
// ----------------------------------------------------------------------------
module upd_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire upd_pkg::t_in  i_data,
    input  wire upd_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output upd_pkg::t_cell     o_cell
);

    typedef struct packed {
        logic                          direct;
        logic                          accel;
        logic                          idle;
        logic [upd_pkg::WIN_BITS-1:0]  win;
        logic [upd_pkg::WIN_BITS-1:0]  tleft;
        logic [upd_pkg::SIZE_BITS-1:0] left;
        logic [upd_pkg::SIZE_BITS-1:0] size_tot;
    } t_s1;

    typedef struct packed {
        logic                          direct;
        logic                          accel;
        logic                          idle;
        logic [upd_pkg::WIN_BITS-1:0]  win;
        logic [upd_pkg::SIZE_BITS-1:0] left;
        logic [upd_pkg::PROD_BITS-1:0] have;
        logic [upd_pkg::PROD_BITS-1:0] owe;
    } t_s2;

    logic                          active;
    logic                          busy;
    logic                          ok;
    logic                          accel;
    logic [upd_pkg::TIME_BITS-1:0] since_fin;
    logic [upd_pkg::TIME_BITS-1:0] since_call;
    logic [upd_pkg::WIN_BITS-1:0]  win;
    logic [upd_pkg::SIZE_BITS-1:0] left;
    logic [upd_pkg::SIZE_BITS-1:0] size_tot;
    t_s1                           n_s1;
    t_s1                           r_s1;
    t_s2                           n_s2;
    t_s2                           r_s2;
    logic                          r_s1_valid;
    logic                          r_s2_valid;

    always_comb begin
        busy       = i_data.standard_in_progress;
        active     = !i_data.link_down && (busy || !i_data.standard_queue_empty);
        accel      = i_data.accelerate_in || (active && busy && !i_data.control_queue_empty);
        win        = accel ? i_cfg.accel_window_ms : i_cfg.normal_window_ms;
        since_fin  = i_data.now_ms - i_data.last_finished_ms;
        since_call = i_data.now_ms - i_data.last_call_ms;
        ok         = busy || i_data.front_valid;
        if (busy) begin
            left     = (i_data.current_sent > i_data.current_length) ? '0
                       : i_data.current_length - i_data.current_sent;
            size_tot = i_data.current_length;
        end else begin
            left     = i_data.front_length;
            size_tot = i_data.front_length;
        end

        n_s1.accel    = accel;
        n_s1.idle     = since_call >= upd_pkg::TIME_BITS'(i_cfg.idle_probe_ms);
        n_s1.win      = win;
        n_s1.tleft    = win - since_fin[upd_pkg::WIN_BITS-1:0];
        n_s1.size_tot = size_tot;
        if (!active || !ok) begin
            n_s1.direct = 1'b1;
            n_s1.left   = '0;
        end else if (since_fin >= upd_pkg::TIME_BITS'(win)) begin
            n_s1.direct = 1'b1;
            n_s1.left   = left;
        end else begin
            n_s1.direct = 1'b0;
            n_s1.left   = left;
        end
    end

    always_comb begin
        n_s2.direct = r_s1.direct;
        n_s2.accel  = r_s1.accel;
        n_s2.idle   = r_s1.idle;
        n_s2.win    = r_s1.win;
        n_s2.left   = r_s1.left;
        n_s2.have   = upd_pkg::PROD_BITS'(r_s1.tleft) * upd_pkg::PROD_BITS'(r_s1.size_tot);
        n_s2.owe    = upd_pkg::PROD_BITS'(r_s1.win) * upd_pkg::PROD_BITS'(r_s1.left);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    always_comb begin
        o_valid        = r_s2_valid;
        o_cell.accel   = r_s2.accel;
        o_cell.divisor = r_s2.win;
        o_cell.rem     = r_s2.have[upd_pkg::PROD_BITS-1:upd_pkg::SIZE_BITS];
        o_cell.dq      = r_s2.have[upd_pkg::SIZE_BITS-1:0];
        if (r_s2.direct) begin
            o_cell.div_mode = 1'b0;
            o_cell.left     = r_s2.left;
        end else if (r_s2.have >= r_s2.owe) begin
            o_cell.div_mode = 1'b0;
            o_cell.left     = upd_pkg::SIZE_BITS'(r_s2.idle);
        end else begin
            o_cell.div_mode = 1'b1;
            o_cell.left     = r_s2.left;
        end
    end

endmodule
`default_nettype wire

// File: rtl/upd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_div_cell
// One restoring division step: develops one allowance bit and hands the
// partial remainder and the rest of the request to the next cell.
// ----------------------------------------------------------------------------
module upd_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire upd_pkg::t_cell i_cell,
    output logic                o_valid,
    output upd_pkg::t_cell      o_cell
);

    logic [upd_pkg::WIN_BITS:0] trial;
    logic [upd_pkg::WIN_BITS:0] diff;
    logic                       fits;
    upd_pkg::t_cell             n_cell;
    upd_pkg::t_cell             r_cell;
    logic                       r_valid;

    always_comb begin
        trial  = {i_cell.rem, i_cell.dq[upd_pkg::SIZE_BITS-1]};
        diff   = trial - {1'b0, i_cell.divisor};
        fits   = trial >= {1'b0, i_cell.divisor};
        n_cell = i_cell;
        n_cell.rem = fits ? diff[upd_pkg::WIN_BITS-1:0] : trial[upd_pkg::WIN_BITS-1:0];
        n_cell.dq  = {i_cell.dq[upd_pkg::SIZE_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule
`default_nettype wire

// File: rtl/upd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_out_buf
// Turns the allowance into the byte demand and holds results in an output
// register backed by a skid stage.
// ----------------------------------------------------------------------------
module upd_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire upd_pkg::t_cell i_cell,
    output logic                o_en,
    output logic                o_valid,
    input  wire logic           i_ready,
    output upd_pkg::t_out       o_data
);

    logic [upd_pkg::SIZE_BITS-1:0] need;
    logic                          deliver;
    logic                          take;
    upd_pkg::t_out                 res;
    upd_pkg::t_out                 r_out;
    upd_pkg::t_out                 r_skid;
    logic                          r_out_valid;
    logic                          r_skid_valid;

    always_comb begin
        if (!i_cell.div_mode || i_cell.dq == '0) begin
            need = i_cell.left;
        end else if (i_cell.dq < i_cell.left) begin
            need = i_cell.left - i_cell.dq + upd_pkg::SIZE_BITS'(1);
        end else begin
            need = upd_pkg::SIZE_BITS'(1);
        end
        res.needed_bytes   = upd_pkg::NEED_BITS'(need);
        res.accelerate_out = i_cell.accel;
    end

    assign o_en    = !r_skid_valid;
    assign deliver = i_valid && !r_skid_valid;
    assign take    = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (deliver) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (deliver) begin
            if (!r_out_valid || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire
